[rtl/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg
// shared types, widths and constants of the slider-crank position block
// ----------------------------------------------------------------------------
package scp_pkg;

    // defaults for the top level parameters
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // all coordinates are in units of 1/2^COORD_FRAC_BITS mm
    localparam int COORD_FRAC_BITS = 4;

    localparam int ATAN_LEN    = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int RADIUS_W    = 16;
    localparam int ROD_W       = 16;
    localparam int ORG_W       = 20;
    localparam int DIR_W       = 16;
    localparam int OUT_W       = 24;
    localparam int CV_W        = 34;
    localparam int PIN_W       = 20;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [RADIUS_W-1:0]     RADIUS_RST = 16'd800;
    localparam logic [ROD_W-1:0]        ROD_RST    = 16'd1120;
    localparam logic signed [ORG_W-1:0] ORG_X_RST  = 20'sd0;
    localparam logic signed [ORG_W-1:0] ORG_Y_RST  = 20'sd0;
    localparam logic signed [DIR_W-1:0] DIR_X_RST  = 16'sd0;
    localparam logic signed [DIR_W-1:0] DIR_Y_RST  = 16'sd20;

    // 0.60725293 in Q30, the start vector of the rotator
    localparam logic signed [CV_W-1:0] CORDIC_X0 = 34'sd652032874;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 3'd0,
        CFG_ROD    = 3'd1,
        CFG_ORG_X  = 3'd2,
        CFG_ORG_Y  = 3'd3,
        CFG_DIR_X  = 3'd4,
        CFG_DIR_Y  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [RADIUS_W-1:0]     radius;
        logic [ROD_W-1:0]        rod;
        logic signed [ORG_W-1:0] org_x;
        logic signed [ORG_W-1:0] org_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
    } t_cfg;

    // crank pin request between front, queue and back
    typedef struct packed {
        logic                    valid;
        logic signed [PIN_W-1:0] cx;
        logic signed [PIN_W-1:0] cy;
    } t_pin_req;

endpackage

[rtl/scp_front.sv]
// ----------------------------------------------------------------------------
// scp_front
// pipelined cordic rotator and crank pin placement
// ----------------------------------------------------------------------------
module scp_front #(
    parameter int ANGLE_BITS    = scp_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = scp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [ANGLE_BITS-1:0]         i_angle,
    input  logic [scp_pkg::RADIUS_W-1:0]  i_radius,
    output scp_pkg::t_pin_req             o_pin
);
    localparam int CW = scp_pkg::CV_W;
    localparam int PW = scp_pkg::RADIUS_W + 1 + CW;

    logic [31:0] phase;
    logic [31:0] phase_rnd;
    logic [1:0]  quad;
    logic [31:0] resid;

    logic signed [CW-1:0] r_x [CORDIC_STAGES+1];
    logic signed [CW-1:0] r_y [CORDIC_STAGES+1];
    logic signed [CW-1:0] r_z [CORDIC_STAGES+1];
    logic [1:0]           r_q [CORDIC_STAGES+1];
    logic                 r_v [CORDIC_STAGES+1];

    logic signed [CW-1:0] n_cos, n_sin;
    logic signed [CW-1:0] r_cos, r_sin;
    logic                 r_v1, r_v2, r_v3;
    logic signed [PW-1:0] r_pc, r_ps;
    logic signed [PW-1:0] rnd_c, rnd_s;
    logic signed [scp_pkg::PIN_W-1:0] r_cx, r_cy;

    // nearest quarter turn and signed residual
    assign phase     = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign phase_rnd = phase + 32'h2000_0000;
    assign quad      = phase_rnd[31:30];
    assign resid     = phase - {quad, 30'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_take;
        end
        r_x[0] <= scp_pkg::CORDIC_X0;
        r_y[0] <= '0;
        r_z[0] <= {{(CW-32){resid[31]}}, resid};
        r_q[0] <= quad;
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
        logic signed [CW-1:0] xs, ys, at;
        logic signed [CW-1:0] n_x, n_y, n_z;
        always_comb begin
            xs = r_x[g] >>> g;
            ys = r_y[g] >>> g;
            at = $signed({{(CW-32){1'b0}}, scp_pkg::ATAN_TAB[g]});
            if (!r_z[g][CW-1]) begin
                n_x = r_x[g] - ys;
                n_y = r_y[g] + xs;
                n_z = r_z[g] - at;
            end else begin
                n_x = r_x[g] + ys;
                n_y = r_y[g] - xs;
                n_z = r_z[g] + at;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            r_x[g+1] <= n_x;
            r_y[g+1] <= n_y;
            r_z[g+1] <= n_z;
            r_q[g+1] <= r_q[g];
        end
    end

    // exact quarter-turn rotation
    always_comb begin
        unique case (r_q[CORDIC_STAGES])
            2'd0: begin n_cos = r_x[CORDIC_STAGES];  n_sin = r_y[CORDIC_STAGES];  end
            2'd1: begin n_cos = -r_y[CORDIC_STAGES]; n_sin = r_x[CORDIC_STAGES];  end
            2'd2: begin n_cos = -r_x[CORDIC_STAGES]; n_sin = -r_y[CORDIC_STAGES]; end
            default: begin n_cos = r_y[CORDIC_STAGES]; n_sin = -r_x[CORDIC_STAGES]; end
        endcase
    end

    assign rnd_c = r_pc + (PW'(1) <<< 29);
    assign rnd_s = r_ps + (PW'(1) <<< 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= r_v[CORDIC_STAGES];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_cos <= n_cos;
        r_sin <= n_sin;
        r_pc  <= $signed({1'b0, i_radius}) * r_cos;
        r_ps  <= $signed({1'b0, i_radius}) * r_sin;
        r_cx  <= rnd_c[30 +: scp_pkg::PIN_W];
        r_cy  <= rnd_s[30 +: scp_pkg::PIN_W];
    end

    assign o_pin.valid = r_v3;
    assign o_pin.cx    = r_cx;
    assign o_pin.cy    = r_cy;

endmodule

[rtl/scp_queue.sv]
// ----------------------------------------------------------------------------
// scp_queue
// short fifo of crank pin requests between front and back
// ----------------------------------------------------------------------------
module scp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scp_pkg::t_pin_req i_push,
    output scp_pkg::t_pin_req o_head,
    output logic              o_full
);
    localparam int DEPTH = scp_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [scp_pkg::PIN_W-1:0] r_cx [DEPTH];
    logic signed [scp_pkg::PIN_W-1:0] r_cy [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    // back end never stalls, so the head leaves as soon as it is there
    assign pop = (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push.valid && pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push.valid) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
        end
        if (i_push.valid) begin
            r_cx[r_wr] <= i_push.cx;
            r_cy[r_wr] <= i_push.cy;
        end
    end

    assign o_head.valid = pop;
    assign o_head.cx    = r_cx[r_rd];
    assign o_head.cy    = r_cy[r_rd];
    assign o_full       = (r_count == CNT_W'(DEPTH));

endmodule

[rtl/scp_back.sv]
// ----------------------------------------------------------------------------
// scp_back
// axis geometry, pipelined square root and rounding division
// ----------------------------------------------------------------------------
module scp_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scp_pkg::t_cfg                    i_cfg,
    input  scp_pkg::t_pin_req                i_head,
    output logic                             o_done,
    output logic                             o_valid_res,
    output logic signed [scp_pkg::OUT_W-1:0] o_pin_x,
    output logic signed [scp_pkg::OUT_W-1:0] o_pin_y
);
    localparam int WW  = 22;
    localparam int PRW = 38;
    localparam int DW  = 39;
    localparam int SQN = 32;
    localparam int NW  = 41;
    localparam int MW  = 57;
    localparam int RW  = 58;
    localparam int QB  = 26;
    localparam int SW  = 29;
    localparam logic signed [SW-1:0] SAT_MAX = SW'((1 <<< (scp_pkg::OUT_W - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_MIN = -SW'(1 <<< (scp_pkg::OUT_W - 1));

    // values that follow from the configuration only
    logic [31:0] r_d2, r_rod2;
    logic [63:0] r_r2d;
    logic signed [31:0] sq_x, sq_y;

    assign sq_x = i_cfg.dir_x * i_cfg.dir_x;
    assign sq_y = i_cfg.dir_y * i_cfg.dir_y;

    always_ff @(posedge i_clk) begin
        r_d2   <= 32'(sq_x) + 32'(sq_y);
        r_rod2 <= 32'(i_cfg.rod) * 32'(i_cfg.rod);
        r_r2d  <= 64'(r_rod2) * 64'(r_d2);
    end

    logic                 r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic signed [WW-1:0] r1_wx, r1_wy;
    logic signed [PRW-1:0] r2_a, r2_b, r2_c, r2_d;
    logic signed [DW-1:0] r3_dot, r3_cross, r4_dot, r5_dot, r6_dot;
    logic [DW-2:0]        cmag;
    logic [31:0]          r4_c32;
    logic                 r4_bad, r5_bad, r6_bad;
    logic [63:0]          r5_sq;
    logic [64:0]          disc;
    logic [63:0]          r6_rem;

    assign cmag = r3_cross[DW-1] ? (DW-1)'(-r3_cross) : (DW-1)'(r3_cross);
    assign disc = {1'b0, r_r2d} - {1'b0, r5_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0;
            r4_v <= 1'b0; r5_v <= 1'b0; r6_v <= 1'b0;
        end else begin
            r1_v <= i_head.valid; r2_v <= r1_v; r3_v <= r2_v;
            r4_v <= r3_v; r5_v <= r4_v; r6_v <= r5_v;
        end
        r1_wx    <= WW'(i_cfg.org_x) - WW'(i_head.cx);
        r1_wy    <= WW'(i_cfg.org_y) - WW'(i_head.cy);
        r2_a     <= r1_wx * i_cfg.dir_x;
        r2_b     <= r1_wy * i_cfg.dir_y;
        r2_c     <= r1_wx * i_cfg.dir_y;
        r2_d     <= r1_wy * i_cfg.dir_x;
        r3_dot   <= DW'(r2_a) + DW'(r2_b);
        r3_cross <= DW'(r2_c) - DW'(r2_d);
        r4_dot   <= r3_dot;
        r4_c32   <= cmag[31:0];
        r4_bad   <= (cmag[DW-2:32] != '0);
        r5_dot   <= r4_dot;
        r5_bad   <= r4_bad;
        r5_sq    <= 64'(r4_c32) * 64'(r4_c32);
        r6_dot   <= r5_dot;
        r6_bad   <= r5_bad | disc[64];
        r6_rem   <= disc[63:0];
    end

    // square root, one result bit per stage
    logic [63:0]          r_sv  [SQN+1];
    logic [63:0]          r_sr  [SQN+1];
    logic signed [DW-1:0] r_sd  [SQN+1];
    logic                 r_sb  [SQN+1];
    logic                 r_svl [SQN+1];

    assign r_sv[0]  = r6_rem;
    assign r_sr[0]  = '0;
    assign r_sd[0]  = r6_dot;
    assign r_sb[0]  = r6_bad;
    assign r_svl[0] = r6_v;

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
        logic [63:0] trial;
        logic [63:0] n_v, n_r;
        always_comb begin
            trial = r_sr[k] + BIT;
            if (r_sv[k] >= trial) begin
                n_v = r_sv[k] - trial;
                n_r = (r_sr[k] >> 1) + BIT;
            end else begin
                n_v = r_sv[k];
                n_r = r_sr[k] >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_svl[k+1] <= 1'b0;
            end else begin
                r_svl[k+1] <= r_svl[k];
            end
            r_sv[k+1] <= n_v;
            r_sr[k+1] <= n_r;
            r_sd[k+1] <= r_sd[k];
            r_sb[k+1] <= r_sb[k];
        end
    end

    logic                 r7_v, r8_v, r9_v;
    logic                 r7_bad, r8_bad, r9_bad;
    logic signed [NW-1:0] r7_num;
    logic signed [MW-1:0] r8_nx, r8_ny;
    logic [MW-1:0]        mag_x, mag_y;
    logic [RW-1:0]        m_x, m_y;
    logic [RW-1:0]        r9_mx, r9_my;
    logic                 r9_sx, r9_sy, r9_bx, r9_by;

    assign mag_x = r8_nx[MW-1] ? MW'(-r8_nx) : MW'(r8_nx);
    assign mag_y = r8_ny[MW-1] ? MW'(-r8_ny) : MW'(r8_ny);
    assign m_x   = RW'(mag_x) + RW'(r_d2 >> 1);
    assign m_y   = RW'(mag_y) + RW'(r_d2 >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0; r8_v <= 1'b0; r9_v <= 1'b0;
        end else begin
            r7_v <= r_svl[SQN]; r8_v <= r7_v; r9_v <= r8_v;
        end
        r7_num <= NW'(r_sr[SQN][32:0]) - NW'(r_sd[SQN]);
        r7_bad <= r_sb[SQN];
        r8_nx  <= i_cfg.dir_x * r7_num;
        r8_ny  <= i_cfg.dir_y * r7_num;
        r8_bad <= r7_bad;
        r9_mx  <= m_x;
        r9_my  <= m_y;
        r9_sx  <= r8_nx[MW-1];
        r9_sy  <= r8_ny[MW-1];
        r9_bx  <= (m_x[RW-1:QB] >= RW'(r_d2));
        r9_by  <= (m_y[RW-1:QB] >= RW'(r_d2));
        r9_bad <= r8_bad;
    end

    // restoring division by d2, quotient clamped where it saturates anyway
    logic [RW-1:0] r_rx [QB+1];
    logic [RW-1:0] r_ry [QB+1];
    logic [QB-1:0] r_qx [QB+1];
    logic [QB-1:0] r_qy [QB+1];
    logic          r_dsx [QB+1], r_dsy [QB+1], r_dbx [QB+1], r_dby [QB+1];
    logic          r_dbad [QB+1], r_dv [QB+1];

    assign r_rx[0]   = r9_mx;
    assign r_ry[0]   = r9_my;
    assign r_qx[0]   = '0;
    assign r_qy[0]   = '0;
    assign r_dsx[0]  = r9_sx;
    assign r_dsy[0]  = r9_sy;
    assign r_dbx[0]  = r9_bx;
    assign r_dby[0]  = r9_by;
    assign r_dbad[0] = r9_bad;
    assign r_dv[0]   = r9_v;

    for (genvar g = 0; g < QB; g++) begin : g_div
        localparam int SH = QB - 1 - g;
        logic [RW-1:0] dv;
        logic          ge_x, ge_y;
        assign dv   = RW'(r_d2) << SH;
        assign ge_x = (r_rx[g] >= dv);
        assign ge_y = (r_ry[g] >= dv);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g+1] <= 1'b0;
            end else begin
                r_dv[g+1] <= r_dv[g];
            end
            r_rx[g+1]     <= ge_x ? r_rx[g] - dv : r_rx[g];
            r_ry[g+1]     <= ge_y ? r_ry[g] - dv : r_ry[g];
            r_qx[g+1]     <= r_qx[g] | (ge_x ? (QB'(1) << SH) : '0);
            r_qy[g+1]     <= r_qy[g] | (ge_y ? (QB'(1) << SH) : '0);
            r_dsx[g+1]    <= r_dsx[g];
            r_dsy[g+1]    <= r_dsy[g];
            r_dbx[g+1]    <= r_dbx[g];
            r_dby[g+1]    <= r_dby[g];
            r_dbad[g+1]   <= r_dbad[g];
        end
    end

    logic [QB:0]          qx, qy;
    logic signed [SW-1:0] sx, sy, tx, ty, fx, fy;
    logic                 ok;

    always_comb begin
        qx = r_dbx[QB] ? (QB+1)'(1) << QB : {1'b0, r_qx[QB]};
        qy = r_dby[QB] ? (QB+1)'(1) << QB : {1'b0, r_qy[QB]};
        sx = r_dsx[QB] ? -SW'(qx) : SW'(qx);
        sy = r_dsy[QB] ? -SW'(qy) : SW'(qy);
        tx = SW'(i_cfg.org_x) + sx;
        ty = SW'(i_cfg.org_y) + sy;
        fx = (tx > SAT_MAX) ? SAT_MAX : ((tx < SAT_MIN) ? SAT_MIN : tx);
        fy = (ty > SAT_MAX) ? SAT_MAX : ((ty < SAT_MIN) ? SAT_MIN : ty);
        ok = !r_dbad[QB] && (r_d2 != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_dv[QB];
        end
        o_valid_res <= ok;
        o_pin_x     <= ok ? fx[scp_pkg::OUT_W-1:0] : '0;
        o_pin_y     <= ok ? fy[scp_pkg::OUT_W-1:0] : '0;
    end

endmodule

[rtl/slider_crank_position_top.sv]
// ----------------------------------------------------------------------------
// slider_crank_position_top
// crank angle in, position of the rod's far pin on the cylinder axis out
// ----------------------------------------------------------------------------
// One crank angle is taken each cycle while busy is low, and every request
// yields exactly one result, shown for a single cycle with o_done high; the
// receiver cannot hold results off, so it must take each one as it comes.
// The whole path is pipelined: a request goes through the cordic rotator,
// the queue, the 32-step square root and the 26-step rounding division
// from start to o_done, and one request follows the next every cycle
// while busy is low. Configuration registers may only be written while
// nothing is in flight; the values that follow from them are registered
// in r_d2, r_rod2 and r_r2d. o_valid_res low means the axis direction is
// zero or the rod cannot reach the axis, and the coordinates are then zero.
// Coordinates are signed, in 1/16 mm, saturated to 24 bits.
// ----------------------------------------------------------------------------
module slider_crank_position_top #(
    parameter int ANGLE_BITS    = scp_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = scp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request side
    input  logic                               start,
    output logic                               busy,
    input  logic [ANGLE_BITS-1:0]              i_crank_angle,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [scp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [scp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // result side
    output logic                               o_done,
    output logic                               o_valid_res,
    output logic signed [scp_pkg::OUT_W-1:0]   o_pin_x,
    output logic signed [scp_pkg::OUT_W-1:0]   o_pin_y
);

    scp_pkg::t_cfg     r_cfg;
    scp_pkg::t_pin_req front_pin;
    scp_pkg::t_pin_req head;
    logic              take;
    logic              q_full;

    // register file, values masked to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius <= scp_pkg::RADIUS_RST;
            r_cfg.rod    <= scp_pkg::ROD_RST;
            r_cfg.org_x  <= scp_pkg::ORG_X_RST;
            r_cfg.org_y  <= scp_pkg::ORG_Y_RST;
            r_cfg.dir_x  <= scp_pkg::DIR_X_RST;
            r_cfg.dir_y  <= scp_pkg::DIR_Y_RST;
        end else if (i_cfg_we) begin
            unique case (scp_pkg::t_cfg_idx'(i_cfg_idx))
                scp_pkg::CFG_RADIUS: r_cfg.radius <= i_cfg_data[scp_pkg::RADIUS_W-1:0];
                scp_pkg::CFG_ROD:    r_cfg.rod    <= i_cfg_data[scp_pkg::ROD_W-1:0];
                scp_pkg::CFG_ORG_X:  r_cfg.org_x  <= i_cfg_data[scp_pkg::ORG_W-1:0];
                scp_pkg::CFG_ORG_Y:  r_cfg.org_y  <= i_cfg_data[scp_pkg::ORG_W-1:0];
                scp_pkg::CFG_DIR_X:  r_cfg.dir_x  <= i_cfg_data[scp_pkg::DIR_W-1:0];
                scp_pkg::CFG_DIR_Y:  r_cfg.dir_y  <= i_cfg_data[scp_pkg::DIR_W-1:0];
                // indexes past the list are dropped
                default: ;
            endcase
        end
    end

    // a request enters on start while the queue has room
    assign take = start && !busy;
    assign busy = q_full;

    // front: angle to crank pin
    scp_front #(
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_angle  (i_crank_angle),
        .i_radius (r_cfg.radius),
        .o_pin    (front_pin)
    );

    // decoupling queue
    scp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_pin),
        .o_head  (head),
        .o_full  (q_full)
    );

    // back: crank pin to position on the axis
    scp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_done      (o_done),
        .o_valid_res (o_valid_res),
        .o_pin_x     (o_pin_x),
        .o_pin_y     (o_pin_y)
    );

endmodule

[rtl/scp_checker.sv]
// ----------------------------------------------------------------------------
// scp_checker
// port-level checks on the slider-crank position block
// ----------------------------------------------------------------------------
module scp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             busy,
    input logic                             o_done,
    input logic                             o_valid_res,
    input logic signed [scp_pkg::OUT_W-1:0] o_pin_x,
    input logic signed [scp_pkg::OUT_W-1:0] o_pin_y
);

    // no result right after reset
    a_no_done_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    // queue is empty right after reset
    a_no_busy_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy)
        else $error("busy right after reset");

    // an unreachable result carries zero coordinates
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_valid_res) |-> (o_pin_x == '0 && o_pin_y == '0))
        else $error("invalid result with nonzero coordinates");

endmodule

bind slider_crank_position_top scp_checker u_scp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_done      (o_done),
    .o_valid_res (o_valid_res),
    .o_pin_x     (o_pin_x),
    .o_pin_y     (o_pin_y)
);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the slider-crank position block
// ----------------------------------------------------------------------------
// Crank angles are queued by the stimulus process and driven one at a time
// by a clocked driver with random gaps. For every accepted request the bench
// computes the expected pin position with its own fixed-point kinematics
// model: a CORDIC rotator, an exact integer square root and a rounding
// division. A clocked monitor compares each o_done strobe against the
// oldest expected position. The run moves through several linkage and axis
// geometries, extremes included, with a directed set and random angles in
// each one.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = scp_pkg::CORDIC_STAGES_DEF + 73;
    localparam int OW      = scp_pkg::OUT_W;

    // expected position of the far rod pin
    typedef struct {
        logic                 reach;
        logic signed [OW-1:0] px;
        logic signed [OW-1:0] py;
    } t_pin_pos;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [15:0]                        i_crank_angle;
    logic                               i_cfg_we;
    logic [scp_pkg::CFG_IDX_W-1:0]      i_cfg_idx;
    logic [scp_pkg::CFG_DATA_W-1:0]     i_cfg_data;
    logic                               o_done;
    logic                               o_valid_res;
    logic signed [OW-1:0]               o_pin_x;
    logic signed [OW-1:0]               o_pin_y;

    slider_crank_position_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_crank_angle (i_crank_angle),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_valid_res   (o_valid_res),
        .o_pin_x       (o_pin_x),
        .o_pin_y       (o_pin_y)
    );

    // shadow of the geometry registers
    longint unsigned geo_radius, geo_rod;
    longint          geo_org_x, geo_org_y, geo_dir_x, geo_dir_y;

    logic [15:0] angle_queue[$];
    t_pin_pos    expected_pos[$];
    int          mismatches;
    int          strobes_checked;
    int          gap_left;
    bit          cfg_busy;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // the whole run must fit here, even with every gap at its longest
    initial begin
        #20ms;
        $display("timeout with %0d positions still expected", expected_pos.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint asr_ll(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // rounds to nearest, halves away from zero
    function automatic longint round_div(longint n, longint unsigned d);
        longint unsigned mag, q;
        mag = (n < 0) ? longint'(-n) : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // crank angle to expected pin position under the current geometry
    function automatic t_pin_pos pin_position(logic [15:0] angle);
        t_pin_pos        p;
        logic [31:0]     phase, resid;
        logic [1:0]      quad;
        longint          x, y, z, xs, ys, cs, sn, cx, cy, wx, wy, dot, crs, num;
        longint unsigned d2, cmag, r2d, s;
        p.reach = 1'b0;
        p.px = '0;
        p.py = '0;
        phase = {angle, 16'h0};
        quad  = 2'((phase + 32'h2000_0000) >> 30);
        resid = phase - {quad, 30'h0};
        z = longint'(signed'(resid));
        x = 652032874;
        y = 0;
        for (int i = 0; i < scp_pkg::CORDIC_STAGES_DEF; i++) begin
            xs = asr_ll(x, i);
            ys = asr_ll(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(scp_pkg::ATAN_TAB[i]);
            end else begin
                x += ys; y -= xs; z += longint'(scp_pkg::ATAN_TAB[i]);
            end
        end
        case (quad)
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
        cx = asr_ll(longint'(geo_radius) * cs + (64'sd1 <<< 29), 30);
        cy = asr_ll(longint'(geo_radius) * sn + (64'sd1 <<< 29), 30);
        d2 = geo_dir_x * geo_dir_x + geo_dir_y * geo_dir_y;
        if (d2 == 0) return p;
        wx  = geo_org_x - cx;
        wy  = geo_org_y - cy;
        dot = wx * geo_dir_x + wy * geo_dir_y;
        crs = wx * geo_dir_y - wy * geo_dir_x;
        cmag = (crs < 0) ? longint'(-crs) : crs;
        if (cmag >= 64'h1_0000_0000) return p;
        r2d = geo_rod * geo_rod * d2;
        if (cmag * cmag > r2d) return p;
        s = root_floor(r2d - cmag * cmag);
        num = longint'(s) - dot;
        p.reach = 1'b1;
        p.px = OW'(clamp24(geo_org_x + round_div(geo_dir_x * num, d2)));
        p.py = OW'(clamp24(geo_org_y + round_div(geo_dir_y * num, d2)));
        return p;
    endfunction

    // driver: one request per queued angle, random gap before each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= $urandom_range(0, 11);
        end else if (start && !busy) begin
            // request taken at this edge
            expected_pos.push_back(pin_position(i_crank_angle));
            void'(angle_queue.pop_front());
            if (angle_queue.size() != 0 && $urandom_range(0, 11) == 0) begin
                gap_left <= $urandom_range(1, 11);
                start    <= 1'b0;
            end else if (angle_queue.size() != 0) begin
                // a third of the time run back to back
                if ($urandom_range(0, 2) == 0) begin
                    start         <= 1'b1;
                    i_crank_angle <= angle_queue[0];
                end else begin
                    gap_left <= $urandom_range(0, 11);
                    start    <= 1'b0;
                end
            end else begin
                start <= 1'b0;
            end
        end else if (!start && !cfg_busy && angle_queue.size() != 0) begin
            if (gap_left == 0) begin
                start         <= 1'b1;
                i_crank_angle <= angle_queue[0];
            end else begin
                gap_left <= gap_left - 1;
            end
        end
    end

    // monitor: each strobe against the oldest expected position
    always @(posedge i_clk) begin
        t_pin_pos want;
        if (i_rst_n && o_done) begin
            if (expected_pos.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request pending: %b %0d %0d",
                             o_valid_res, o_pin_x, o_pin_y);
            end else begin
                want = expected_pos.pop_front();
                strobes_checked++;
                if (o_valid_res !== want.reach || o_pin_x !== want.px
                        || o_pin_y !== want.py) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pin mismatch: expected %b %0d %0d, got %b %0d %0d",
                                 want.reach, want.px, want.py,
                                 o_valid_res, o_pin_x, o_pin_y);
                end
            end
        end
    end

    // one register write at an edge, shadow updated with the same masking
    task automatic write_reg(scp_pkg::t_cfg_idx idx,
                             logic [scp_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            scp_pkg::CFG_RADIUS: geo_radius = val[15:0];
            scp_pkg::CFG_ROD:    geo_rod    = val[15:0];
            scp_pkg::CFG_ORG_X:  geo_org_x  = longint'(signed'(val[19:0]));
            scp_pkg::CFG_ORG_Y:  geo_org_y  = longint'(signed'(val[19:0]));
            scp_pkg::CFG_DIR_X:  geo_dir_x  = longint'(signed'(val[15:0]));
            scp_pkg::CFG_DIR_Y:  geo_dir_y  = longint'(signed'(val[15:0]));
            default: ;
        endcase
    endtask

    task automatic set_geometry(int r, int l, int ox, int oy, int dx, int dy);
        write_reg(scp_pkg::CFG_RADIUS, 20'(r));
        write_reg(scp_pkg::CFG_ROD, 20'(l));
        write_reg(scp_pkg::CFG_ORG_X, 20'(ox));
        write_reg(scp_pkg::CFG_ORG_Y, 20'(oy));
        write_reg(scp_pkg::CFG_DIR_X, 20'(dx));
        write_reg(scp_pkg::CFG_DIR_Y, 20'(dy));
        // let the written values settle before any request
        repeat (3) @(posedge i_clk);
    endtask

    // wait until every request of this phase has come back
    task automatic drain();
        while (angle_queue.size() != 0 || start || expected_pos.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // quarter turns, their neighbours, rounding edges and the angle extremes
    task automatic queue_directed();
        logic [15:0] corners[$];
        corners = '{16'h0000, 16'h0001, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                    16'h1FFF, 16'h2000, 16'h6000, 16'hA000, 16'hE000, 16'h3FFF,
                    16'h7FFF, 16'h8001, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0};
        foreach (corners[i]) angle_queue.push_back(corners[i]);
    endtask

    task automatic run_phase(int n_rand);
        queue_directed();
        repeat (n_rand) angle_queue.push_back(16'($urandom));
        cfg_busy = 1'b0;
        drain();
        cfg_busy = 1'b1;
    endtask

    initial begin
        int r, l, ox, oy, dx, dy;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_crank_angle = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = scp_pkg::CFG_RADIUS;
        i_cfg_data    = '0;
        mismatches    = 0;
        strobes_checked = 0;
        gap_left      = 0;
        cfg_busy      = 1'b1;
        geo_radius = scp_pkg::RADIUS_RST; geo_rod = scp_pkg::ROD_RST;
        geo_org_x = scp_pkg::ORG_X_RST;   geo_org_y = scp_pkg::ORG_Y_RST;
        geo_dir_x = scp_pkg::DIR_X_RST;   geo_dir_y = scp_pkg::DIR_Y_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset geometry: vertical axis through the crank centre
        run_phase(30);
        // horizontal axis, offset origin
        set_geometry(800, 1120, -300, 150, 7, 0);
        run_phase(30);
        // zero direction, never reachable
        set_geometry(1000, 2000, 0, 0, 0, 0);
        run_phase(10);
        // axis far off, rod too short for most angles, tangent near miss
        set_geometry(800, 1000, 0, 1800, 1, 0);
        run_phase(20);
        // full-scale everything, saturating outputs
        set_geometry(65535, 65535, 524287, -524288, -32768, 32767);
        run_phase(20);
        set_geometry(65535, 65535, -524288, 524287, 32767, -32768);
        run_phase(20);
        // zero radius and zero rod
        set_geometry(0, 0, 0, 0, 3, 4);
        run_phase(10);
        set_geometry(0, 500, 524287, 524287, -1, -1);
        run_phase(10);
        // random geometries, most with a reachable axis
        repeat (4) begin
            r  = $urandom_range(0, 65535);
            l  = $urandom_range(0, 65535);
            ox = $urandom_range(0, 1048575) - 524288;
            oy = $urandom_range(0, 1048575) - 524288;
            dx = $urandom_range(0, 65535) - 32768;
            dy = $urandom_range(0, 65535) - 32768;
            if ($urandom_range(0, 3) != 0) begin
                r  = $urandom_range(0, 4000);
                l  = r + $urandom_range(0, 8000);
                ox = $urandom_range(0, 2000) - 1000;
                oy = $urandom_range(0, 2000) - 1000;
            end
            set_geometry(r, l, ox, oy, dx, dy);
            run_phase(15);
        end

        repeat (LATENCY + 20) @(posedge i_clk);
        $display("checked %0d pin positions over 12 geometries", strobes_checked);
        $display("zero-direction, unreachable, saturating and random axes covered");
        if (mismatches == 0 && expected_pos.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d positions never arrived",
                     mismatches, expected_pos.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/scp_pkg.sv
rtl/scp_front.sv
rtl/scp_queue.sv
rtl/scp_back.sv
rtl/slider_crank_position_top.sv
rtl/scp_checker.sv
dv/testbench.sv
